[src/otc_pkg.sv]
// shared types, codes and constants of the oven timer controller
`default_nettype none

package otc_pkg;

    // remaining time counter width
    localparam int TIME_W = 16;
    localparam int unsigned TIME_MAX_I = (32'd1 << TIME_W) - 32'd1;
    localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(TIME_MAX_I);

    // display digits of the saturated time
    localparam logic [6:0] SAT_D0 = 7'(TIME_MAX_I / 600);
    localparam logic [3:0] SAT_D1 = 4'((TIME_MAX_I % 600) / 60);
    localparam logic [3:0] SAT_D2 = 4'((TIME_MAX_I % 60) / 10);
    localparam logic [3:0] SAT_D3 = 4'(TIME_MAX_I % 10);

    // port widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK  = 2'd2;

    // key codes
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_START = 8'h23;
    localparam logic [7:0] KEY_STOP  = 8'h2A;

    typedef enum logic {
        OP_KEY,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READY,
        MODE_WORKING,
        MODE_SUSPEND
    } mode_t;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_DOOR,
        MSG_EMPTY,
        MSG_OVER,
        MSG_HEAT,
        MSG_PAUSE,
        MSG_DONE
    } msg_t;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] key_code;
        logic [9:0] door_level;
        logic [9:0] weight_level;
    } item_t;

    typedef struct packed {
        logic [9:0] door_closed_level;
        logic [9:0] weight_limit;
        logic [7:0] quick_add_seconds;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        door_closed_level: 10'd1023,
        weight_limit:      10'd500,
        quick_add_seconds: 8'd30
    };

    typedef struct packed {
        mode_t       mode;
        msg_t        message;
        logic        heater_on;
        logic [15:0] time_left;
        logic [6:0]  minutes_tens;
        logic [3:0]  minutes_ones;
        logic [3:0]  secs_tens;
        logic [3:0]  secs_ones;
        logic        finished;
    } result_t;

endpackage

`default_nettype wire

[src/oven_timer_controller.sv]
// oven timer controller top level: item registers, configuration and handshakes
// throughput: one item per cycle while the result side is not stalled; the state update is one pass through otc_step
// between the input register and the result register
// reset: mode idle, no digits typed, digits and remaining time zero, door level 1023,
// weight limit 500, quick add 30 s; both item registers empty
`default_nettype none

module oven_timer_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    // key_code [7:0], door_level [17:8], weight_level [27:18], zero [31:28]
    input  logic [otc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode [0]
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // mode [1:0], message [4:2], heater_on [5], time_left [21:6],
    // minutes_tens [28:22], minutes_ones [32:29], secs_tens [36:33],
    // secs_ones [40:37], finished [41], zero [47:42]
    output logic [otc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [otc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [otc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import otc_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    in_fire, adv;

    // handshakes
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DOOR:   cfg_reg.door_closed_level <= cfg_data;
                CFG_WEIGHT: cfg_reg.weight_limit      <= cfg_data;
                CFG_QUICK:  cfg_reg.quick_add_seconds <= cfg_data[7:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.opcode       <= op_t'(s_axis_tuser);
            item_reg.key_code     <= s_axis_tdata[7:0];
            item_reg.door_level   <= s_axis_tdata[17:8];
            item_reg.weight_level <= s_axis_tdata[27:18];
        end
    end

    // state update
    otc_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, result_reg.finished, result_reg.secs_ones,
                            result_reg.secs_tens, result_reg.minutes_ones,
                            result_reg.minutes_tens, result_reg.time_left,
                            result_reg.heater_on, result_reg.message, result_reg.mode};

`ifndef SYNTHESIS
    // heater drive follows the working mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (result_reg.heater_on == (result_reg.mode == MODE_WORKING)))
        else $error("heater drive disagrees with mode");

    // a finished countdown leaves the block idle with zero time
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.finished) |->
        (result_reg.mode == MODE_IDLE && result_reg.message == MSG_DONE &&
         result_reg.time_left == 16'd0))
        else $error("finished without idle state");

    // a held item is not lost or changed while the result side is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(item_reg)))
        else $error("held item dropped");

    // the input side only stalls while an item is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with empty register");
`endif

endmodule

`default_nettype wire

[src/otc_step.sv]
// controller state and the single-pass update for one item
`default_nettype none

module otc_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  otc_pkg::item_t   item,
    input  otc_pkg::cfg_t    cfg,
    output otc_pkg::result_t result
);
    import otc_pkg::*;

    // tens of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] q;
        if (v >= 6'd60)      q = 3'd6;
        else if (v >= 6'd50) q = 3'd5;
        else if (v >= 6'd40) q = 3'd4;
        else if (v >= 6'd30) q = 3'd3;
        else if (v >= 6'd20) q = 3'd2;
        else if (v >= 6'd10) q = 3'd1;
        else                 q = 3'd0;
        return q;
    endfunction

    // state: shown digits d*, digits of remaining time n*
    mode_t             mode_reg, mode_next;
    logic [2:0]        typed_reg, typed_next;
    logic [6:0]        d0_reg, d0_next, n0_reg, n0_next;
    logic [3:0]        d1_reg, d1_next, n1_reg, n1_next;
    logic [3:0]        d2_reg, d2_next, n2_reg, n2_next;
    logic [3:0]        d3_reg, d3_next, n3_reg, n3_next;
    logic [TIME_W-1:0] remaining_reg, remaining_next;

    logic       is_digit, digit_wr;
    logic [3:0] key_val;
    logic [6:0] dw0;
    logic [3:0] dw1, dw2, dw3;

    logic [6:0]  sec_raw;
    logic        sec_carry;
    logic [5:0]  sec_fit;
    logic [4:0]  one_sum;
    logic        one_wrap;
    logic [10:0] mins;
    logic [16:0] load_time;
    logic        load_sat;
    logic [6:0]  ld0;
    logic [3:0]  ld1, ld2, ld3;
    logic [TIME_W-1:0] load_rem;

    logic [TIME_W:0]   quick_sum;
    logic              quick_sat;
    logic [8:0]        qsec;
    logic [2:0]        qmin;
    logic [5:0]        qsec_fit;
    logic [2:0]        qtens;
    logic [4:0]        qmo;
    logic              qcarry;
    logic [6:0]        qd0;
    logic [3:0]        qd1, qd2, qd3;
    logic [TIME_W-1:0] quick_rem;

    logic [6:0] dec0;
    logic [3:0] dec1, dec2, dec3;

    logic door_ok, load_empty, load_over, run_check;
    msg_t msg;
    logic done;

    // key decode and digit write
    assign is_digit = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);
    assign key_val  = 4'(item.key_code - KEY_ZERO);
    assign digit_wr = (item.opcode == OP_KEY) && is_digit && (typed_reg < 3'd4);

    always_comb
    begin
        dw0 = d0_reg;
        dw1 = d1_reg;
        dw2 = d2_reg;
        dw3 = d3_reg;
        if (digit_wr)
        begin
            unique case (typed_reg[1:0])
                2'd0: dw0 = {3'b000, key_val};
                2'd1: dw1 = key_val;
                2'd2: dw2 = key_val;
                2'd3: dw3 = key_val;
            endcase
        end
    end

    // typed time: normalize mm:ss into seconds and digits
    assign sec_raw   = 7'(dw2) * 7'd10 + 7'(dw3);
    assign sec_carry = sec_raw >= 7'd60;
    assign sec_fit   = sec_carry ? 6'(sec_raw - 7'd60) : 6'(sec_raw);
    assign one_sum   = 5'(dw1) + 5'(sec_carry);
    assign one_wrap  = one_sum >= 5'd10;
    assign mins      = 11'(dw0) * 11'd10 + 11'(dw1) + 11'(sec_carry);
    assign load_time = 17'(mins) * 17'd60 + 17'(sec_fit);
    assign load_sat  = load_time > 17'(TIME_MAX);
    assign load_rem  = load_sat ? TIME_MAX : TIME_W'(load_time);
    assign ld0 = load_sat ? SAT_D0 : dw0 + 7'(one_wrap);
    assign ld1 = load_sat ? SAT_D1 : (one_wrap ? 4'(one_sum - 5'd10) : 4'(one_sum));
    assign ld2 = load_sat ? SAT_D2 : (sec_carry ? dw2 - 4'd6 : dw2);
    assign ld3 = load_sat ? SAT_D3 : dw3;

    // quick add: saturating sum, digits by carrying into the minutes
    assign quick_sum = {1'b0, remaining_reg} + (TIME_W+1)'(cfg.quick_add_seconds);
    assign quick_sat = quick_sum[TIME_W];
    assign quick_rem = quick_sat ? TIME_MAX : quick_sum[TIME_W-1:0];
    assign qsec = 9'(n2_reg) * 9'd10 + 9'(n3_reg) + 9'(cfg.quick_add_seconds);

    always_comb
    begin
        if (qsec >= 9'd300)      qmin = 3'd5;
        else if (qsec >= 9'd240) qmin = 3'd4;
        else if (qsec >= 9'd180) qmin = 3'd3;
        else if (qsec >= 9'd120) qmin = 3'd2;
        else if (qsec >= 9'd60)  qmin = 3'd1;
        else                     qmin = 3'd0;
    end

    assign qsec_fit = 6'(qsec - 9'(qmin) * 9'd60);
    assign qtens    = tens_of(qsec_fit);
    assign qmo      = 5'(n1_reg) + 5'(qmin);
    assign qcarry   = qmo >= 5'd10;
    assign qd0 = quick_sat ? SAT_D0 : n0_reg + 7'(qcarry);
    assign qd1 = quick_sat ? SAT_D1 : (qcarry ? 4'(qmo - 5'd10) : 4'(qmo));
    assign qd2 = quick_sat ? SAT_D2 : 4'(qtens);
    assign qd3 = quick_sat ? SAT_D3 : 4'(qsec_fit - 6'(qtens) * 6'd10);

    // one second down on the remaining time digits
    always_comb
    begin
        dec0 = n0_reg;
        dec1 = n1_reg;
        dec2 = n2_reg;
        dec3 = n3_reg - 4'd1;
        if (n3_reg == 4'd0)
        begin
            dec3 = 4'd9;
            dec2 = n2_reg - 4'd1;
            if (n2_reg == 4'd0)
            begin
                dec2 = 4'd5;
                dec1 = n1_reg - 4'd1;
                if (n1_reg == 4'd0)
                begin
                    dec1 = 4'd9;
                    dec0 = n0_reg - 7'd1;
                end
            end
        end
    end

    // door and load checks
    assign door_ok    = item.door_level == cfg.door_closed_level;
    assign load_empty = item.weight_level == 10'd0;
    assign load_over  = item.weight_level > cfg.weight_limit;

    // event handling
    always_comb
    begin
        mode_next      = mode_reg;
        typed_next     = typed_reg;
        d0_next        = dw0;
        d1_next        = dw1;
        d2_next        = dw2;
        d3_next        = dw3;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        n3_next        = n3_reg;
        remaining_next = remaining_reg;
        msg            = MSG_NONE;
        done           = 1'b0;
        run_check      = 1'b0;

        if (item.opcode == OP_KEY)
        begin
            if (is_digit)
            begin
                if (digit_wr)
                begin
                    typed_next = typed_reg + 3'd1;
                    run_check  = typed_reg == 3'd3;
                end
            end
            else if (item.key_code == KEY_START)
            begin
                if (mode_reg == MODE_SUSPEND)
                begin
                    mode_next = MODE_WORKING;
                    msg       = MSG_HEAT;
                end
                else
                begin
                    run_check = 1'b1;
                end
            end
            else if (item.key_code == KEY_STOP)
            begin
                if (mode_reg == MODE_SUSPEND)
                begin
                    mode_next      = MODE_IDLE;
                    typed_next     = 3'd0;
                    d0_next        = 7'd0;
                    d1_next        = 4'd0;
                    d2_next        = 4'd0;
                    d3_next        = 4'd0;
                    n0_next        = 7'd0;
                    n1_next        = 4'd0;
                    n2_next        = 4'd0;
                    n3_next        = 4'd0;
                    remaining_next = '0;
                end
                else
                begin
                    mode_next = MODE_SUSPEND;
                    msg       = MSG_PAUSE;
                end
            end
        end
        else if (mode_reg == MODE_WORKING)
        begin
            if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - TIME_W'(1);
                n0_next = dec0;
                n1_next = dec1;
                n2_next = dec2;
                n3_next = dec3;
                d0_next = dec0;
                d1_next = dec1;
                d2_next = dec2;
                d3_next = dec3;
            end
            else
            begin
                mode_next      = MODE_IDLE;
                typed_next     = 3'd0;
                d0_next        = 7'd0;
                d1_next        = 4'd0;
                d2_next        = 4'd0;
                d3_next        = 4'd0;
                n0_next        = 7'd0;
                n1_next        = 4'd0;
                n2_next        = 4'd0;
                n3_next        = 4'd0;
                remaining_next = '0;
                msg            = MSG_DONE;
                done           = 1'b1;
            end
        end

        if (run_check)
        begin
            mode_next = MODE_READY;
            priority if (!door_ok)
            begin
                msg = MSG_DOOR;
            end
            else if (load_empty)
            begin
                msg = MSG_EMPTY;
            end
            else if (load_over)
            begin
                msg = MSG_OVER;
            end
            else
            begin
                mode_next = MODE_WORKING;
                msg       = MSG_HEAT;
                if (typed_next == 3'd0)
                begin
                    remaining_next = quick_rem;
                    n0_next = qd0;
                    n1_next = qd1;
                    n2_next = qd2;
                    n3_next = qd3;
                    d0_next = qd0;
                    d1_next = qd1;
                    d2_next = qd2;
                    d3_next = qd3;
                end
                else
                begin
                    remaining_next = load_rem;
                    n0_next = ld0;
                    n1_next = ld1;
                    n2_next = ld2;
                    n3_next = ld3;
                end
            end
        end
    end

    // result of this item
    always_comb
    begin
        result.mode         = mode_next;
        result.message      = msg;
        result.heater_on    = mode_next == MODE_WORKING;
        result.time_left    = 16'(remaining_next);
        result.minutes_tens = d0_next;
        result.minutes_ones = d1_next;
        result.secs_tens    = d2_next;
        result.secs_ones    = d3_next;
        result.finished     = done;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            typed_reg     <= 3'd0;
            d0_reg        <= 7'd0;
            d1_reg        <= 4'd0;
            d2_reg        <= 4'd0;
            d3_reg        <= 4'd0;
            n0_reg        <= 7'd0;
            n1_reg        <= 4'd0;
            n2_reg        <= 4'd0;
            n3_reg        <= 4'd0;
            remaining_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg      <= mode_next;
            typed_reg     <= typed_next;
            d0_reg        <= d0_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            d3_reg        <= d3_next;
            n0_reg        <= n0_next;
            n1_reg        <= n1_next;
            n2_reg        <= n2_next;
            n3_reg        <= n3_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire
